### rtl/base64_stream_encoder_defines.svh
// Assertion macros shared by the Base64 encoder RTL.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

### rtl/b64e_pkg.sv
// Types and constants of the Base64 stream encoder.
package b64e_pkg;

    localparam logic [0:63][7:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    localparam logic [7:0] PAD_CODE = 8'h3D;

    // Position of the next byte inside its three-byte group.
    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    // One queued command: up to four characters for one input byte.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/b64e_stream_if.sv
// Valid/ready stream interfaces for raw bytes and encoded characters.
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

### rtl/b64e_front.sv
// Front end: accept bytes, track group phase and build character commands.
module b64e_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    b64e_byte_if.sink          i_in,
    input  logic               i_full,
    output logic               o_push,
    output b64e_pkg::t_cmd     o_cmd,
    output logic [1:0]         o_phase
);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_left,  n_left;
    logic [7:0] b;
    logic       fin;

    assign b       = i_in.data_byte;
    assign fin     = i_in.final_byte;
    assign i_in.ready = !i_full;
    assign o_push  = i_in.valid && !i_full;
    assign o_phase = r_phase;

    always_comb begin
        o_cmd.chars    = {4{b64e_pkg::PAD_CODE}};
        o_cmd.last_idx = 2'd0;
        o_cmd.last     = fin;
        n_phase        = b64e_pkg::PH_0;
        n_left         = 4'd0;
        case (r_phase)
            b64e_pkg::PH_1: begin
                o_cmd.chars[0] = b64e_pkg::ALPHABET[{r_left[1:0], b[7:4]}];
                if (fin) begin
                    o_cmd.chars[1] = b64e_pkg::ALPHABET[{b[3:0], 2'b00}];
                    o_cmd.last_idx = 2'd2;
                end else begin
                    n_phase = b64e_pkg::PH_2;
                    n_left  = b[3:0];
                end
            end
            b64e_pkg::PH_2: begin
                o_cmd.chars[0] = b64e_pkg::ALPHABET[{r_left, b[7:6]}];
                o_cmd.chars[1] = b64e_pkg::ALPHABET[b[5:0]];
                o_cmd.last_idx = 2'd1;
            end
            default: begin
                o_cmd.chars[0] = b64e_pkg::ALPHABET[b[7:2]];
                if (fin) begin
                    o_cmd.chars[1] = b64e_pkg::ALPHABET[{b[1:0], 4'b0000}];
                    o_cmd.last_idx = 2'd3;
                end else begin
                    n_phase = b64e_pkg::PH_1;
                    n_left  = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH_0;
            r_left  <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

### rtl/b64e_queue.sv
// Small command FIFO between the front and back ends.
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64e_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output b64e_pkg::t_cmd       o_head,
    output b64e_pkg::t_q_status  o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64e_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/b64e_back.sv
// Back end: serialize queued commands into one character per transfer.
module b64e_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  b64e_pkg::t_cmd       i_head,
    input  b64e_pkg::t_q_status  i_status,
    output logic                 o_pop,
    b64e_char_if.source          o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       load;
    logic       at_end;

    assign at_end = (r_idx == i_head.last_idx);
    assign load   = !i_status.empty && (!r_valid || o_out.ready);
    assign o_pop  = load && at_end;

    assign o_out.valid     = r_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_head.chars[r_idx];
            r_last <= i_head.last && at_end;
        end
    end

endmodule

### rtl/base64_stream_encoder.sv
// A transferred byte is written into the command queue; its first character
// is then loaded into the output register, from which it transfers.
// Throughput: one character per cycle out while the consumer is ready; bytes
// enter every cycle while the command queue has room, so a blob's rate is set
// by the single-character output register.
// Reset: i_rst_n low at a clock edge clears phase, queue and output valid.
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64e_byte_if.sink   i_in,
    b64e_char_if.source o_out
);

    // Front end classifies each byte by its group phase and emits one
    // command holding every character that byte produces (one to four).
    b64e_pkg::t_cmd      cmd;
    b64e_pkg::t_cmd      head;
    b64e_pkg::t_q_status q_status;
    logic                push;
    logic                pop;
    logic [1:0]          phase;
    logic                fin_push;

    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_status.full),
        .o_push  (push),
        .o_cmd   (cmd),
        .o_phase (phase)
    );

    // The queue decouples byte intake from character output so that a
    // stalled consumer does not stall the producer until the queue fills.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // Back end walks the head command one character per transfer and
    // drops it as its final character is loaded into the output register.
    b64e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (q_status),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // Transfer of the byte that closes a blob.
    assign fin_push = push && i_in.final_byte;

    // Never write a full queue, never read an empty one, and restart the
    // group after the final byte.
    `B64E_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, push, !q_status.full)
    `B64E_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, pop, !q_status.empty)
    `B64E_ASSERT_NEXT(a_final_restarts, i_clk, i_rst_n, fin_push, phase == b64e_pkg::PH_0)

endmodule

### tb/tb_base64_stream_encoder.sv
// Self-checking testbench of the Base64 stream encoder: directed table, random blobs, predictor.
module tb_base64_stream_encoder;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 8;
    localparam int RAND_BYTES   = 126;
    localparam int GAP_MAX      = 17;
    // Margin after the drain for stray characters to show up.
    localparam int DRAIN_CYCLES = 8;

    // One row of the directed table. Where n_typed is nonzero, the expected
    // characters are typed in, right aligned in typed_chars; otherwise the
    // predictor supplies them.
    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic [2:0]  n_typed;
        logic [31:0] typed_chars;
    } t_stim_row;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_b64_char;

    localparam int N_ROWS = 24;
    localparam t_stim_row DIRECTED [N_ROWS] = '{
        // Classic three-byte group straight after reset.
        '{8'h4D, 1'b0, 3'd1, "T"},
        '{8'h61, 1'b0, 3'd1, "W"},
        '{8'h6E, 1'b1, 3'd2, "Fu"},
        // Single-byte blobs at both extremes: flush plus two pads.
        '{8'h00, 1'b1, 3'd4, "AA=="},
        '{8'hFF, 1'b1, 3'd4, "/w=="},
        // Two-byte blob of ones: flush plus one pad.
        '{8'hFF, 1'b0, 3'd1, "/"},
        '{8'hFF, 1'b1, 3'd3, "/8="},
        // Full group of ones, final on the third byte.
        '{8'hFF, 1'b0, 3'd1, "/"},
        '{8'hFF, 1'b0, 3'd1, "/"},
        '{8'hFF, 1'b1, 3'd2, "//"},
        // Group of zeros that does not end the blob, then a short tail.
        '{8'h00, 1'b0, 3'd1, "A"},
        '{8'h00, 1'b0, 3'd1, "A"},
        '{8'h00, 1'b0, 3'd2, "AA"},
        '{8'h4D, 1'b0, 3'd0, 32'd0},
        '{8'h61, 1'b1, 3'd0, 32'd0},
        // Mixed bit patterns, final landing on each group phase.
        '{8'h80, 1'b0, 3'd0, 32'd0},
        '{8'h01, 1'b0, 3'd0, 32'd0},
        '{8'h7F, 1'b0, 3'd0, 32'd0},
        '{8'hFE, 1'b1, 3'd0, 32'd0},
        '{8'h3C, 1'b0, 3'd0, 32'd0},
        '{8'hC3, 1'b1, 3'd0, 32'd0},
        '{8'h55, 1'b0, 3'd0, 32'd0},
        '{8'hAA, 1'b0, 3'd0, 32'd0},
        '{8'h0F, 1'b1, 3'd0, 32'd0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    b64e_byte_if byte_ch ();
    b64e_char_if char_ch ();

    base64_stream_encoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (char_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // Characters still owed by the encoder, oldest first.
    t_b64_char owed_chars [$];
    // Characters that the byte just transferred produces.
    t_b64_char byte_chars [$];

    // Predictor copy of the encoder state.
    logic [1:0] grp_phase;
    logic [3:0] carry_bits;

    int mismatches = 0;
    // Random idling on both sides; cleared for quiet stretches.
    bit idle_on = 1'b1;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Map a six-bit value onto the standard alphabet.
    function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
        if (v < 6'd26)
            return "A" + 8'(v);
        else if (v < 6'd52)
            return "a" + 8'(v) - 8'd26;
        else if (v < 6'd62)
            return "0" + 8'(v) - 8'd52;
        else if (v == 6'd62)
            return "+";
        return "/";
    endfunction

    // Append one character to the list of the current byte.
    function automatic void add_char(input logic [7:0] code, input logic last);
        byte_chars.insert(byte_chars.size(), t_b64_char'{code, last});
    endfunction

    // Append one character to the owed list.
    function automatic void owe_char(input t_b64_char c);
        owed_chars.insert(owed_chars.size(), c);
    endfunction

    // Advance the predictor by one byte and fill byte_chars.
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        byte_chars.delete();
        case (grp_phase)
            b64e_pkg::PH_1: begin
                add_char(sextet_ascii({carry_bits[1:0], b[7:4]}), 1'b0);
                if (fin) begin
                    add_char(sextet_ascii({b[3:0], 2'b00}), 1'b0);
                    add_char(b64e_pkg::PAD_CODE, 1'b1);
                    grp_phase  = b64e_pkg::PH_0;
                    carry_bits = 4'd0;
                end else begin
                    grp_phase  = b64e_pkg::PH_2;
                    carry_bits = b[3:0];
                end
            end
            b64e_pkg::PH_2: begin
                add_char(sextet_ascii({carry_bits, b[7:6]}), 1'b0);
                add_char(sextet_ascii(b[5:0]), fin);
                grp_phase  = b64e_pkg::PH_0;
                carry_bits = 4'd0;
            end
            default: begin
                // Start of a group; phase 3 never occurs and is handled the same way.
                add_char(sextet_ascii(b[7:2]), 1'b0);
                if (fin) begin
                    add_char(sextet_ascii({b[1:0], 4'b0000}), 1'b0);
                    add_char(b64e_pkg::PAD_CODE, 1'b0);
                    add_char(b64e_pkg::PAD_CODE, 1'b1);
                    grp_phase  = b64e_pkg::PH_0;
                    carry_bits = 4'd0;
                end else begin
                    grp_phase  = b64e_pkg::PH_1;
                    carry_bits = {2'b00, b[1:0]};
                end
            end
        endcase
    endfunction

    // Offer one byte, starting and ending at a falling edge. Hold valid high
    // across back-to-back transfers; drop it only for an idle burst.
    task automatic send_byte(input logic [7:0] b, input logic fin,
                             input logic [2:0] n_typed, input logic [31:0] typed_chars);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, GAP_MAX);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.final_byte <= fin;
        // The transfer happens at the first rising edge with ready high.
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        encode_byte(b, fin);
        if (n_typed != 3'd0) begin
            // Typed rows: take the characters from the table, last flag on
            // the final character of a final byte.
            for (int k = 0; k < int'(n_typed); k++)
                owe_char(t_b64_char'{
                    typed_chars[8 * (int'(n_typed) - 1 - k) +: 8],
                    fin && (k == int'(n_typed) - 1)});
        end else begin
            foreach (byte_chars[k])
                owe_char(byte_chars[k]);
        end
        @(negedge clk);
    endtask

    // Byte source: reset, directed table, then random blobs.
    initial begin
        int n_sent;
        int blob_len;
        logic [7:0] b;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = 8'd0;
        byte_ch.final_byte = 1'b0;
        grp_phase          = b64e_pkg::PH_0;
        carry_bits         = 4'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].data, DIRECTED[i].fin,
                      DIRECTED[i].n_typed, DIRECTED[i].typed_chars);

        // Mostly short blobs, now and then a long one; bias toward the
        // all-zero and all-one bytes.
        n_sent = 0;
        while (n_sent < RAND_BYTES) begin
            // Quiet stretch in the middle, and none at all near the end.
            idle_on  = !(n_sent >= 50 && n_sent < 65) && (n_sent < 100);
            blob_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                   : $urandom_range(1, 6);
            for (int j = 0; j < blob_len; j++) begin
                case ($urandom_range(0, 7))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
                send_byte(b, j == blob_len - 1, 3'd0, 32'd0);
                n_sent++;
            end
        end
        byte_ch.valid <= 1'b0;

        // Drain, then give stray characters a chance to show up.
        while (owed_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Character sink: ready high, with random stall bursts while idling is on.
    initial begin
        int stall;
        char_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, GAP_MAX);
                char_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end else begin
                char_ch.ready <= 1'b1;
            end
        end
    end

    // Compare every character transfer against the oldest owed character.
    always @(posedge clk) begin
        t_b64_char want;
        if (rst_n && char_ch.valid && char_ch.ready) begin
            if (owed_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                          char_ch.char_code, char_ch.last_char));
            end else begin
                want = owed_chars.pop_front();
                if (char_ch.char_code !== want.code)
                    report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                              char_ch.char_code, want.code));
                if (char_ch.last_char !== want.last)
                    report_mismatch($sformatf("last_char %0b, want %0b",
                                              char_ch.last_char, want.last));
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
